### design/sbr_pkg.sv
// ----------------------------------------------------------------------------
// sbr_pkg
// Shared types and codes for the stream byte reassembler.
// ----------------------------------------------------------------------------
`default_nettype none

package sbr_pkg;

	localparam int CNT_W = 7;
	localparam int POS_W = 64;
	localparam int BYTE_W = 8;

	localparam logic [1:0] ACT_DATA    = 2'd0;
	localparam logic [1:0] ACT_END     = 2'd1;
	localparam logic [1:0] ACT_CONSUME = 2'd2;

	typedef struct packed {
		logic              has_byte;
		logic [BYTE_W-1:0] out_byte;
		logic              stream_closed;
		logic [CNT_W-1:0]  pending_bytes;
		logic              last_result;
	} res_t;

endpackage

`default_nettype wire

### design/stream_byte_reassembler.sv
// ----------------------------------------------------------------------------
// stream_byte_reassembler
// Takes stream bytes with absolute positions, one per input transaction, in
// any order and with repeats, and pushes them out in stream order into an
// output of limited room (stream_capacity, 1..BUFFER_BYTES). Early bytes
// inside the window are held in a RAM of BUFFER_BYTES entries, with valid
// bits in flops; a byte at the expected position is pushed and the held bytes
// that follow are drained, one result transaction per pushed byte, or one
// status result when nothing is pushed. An item passes through capture,
// compare and act before its first result is loaded; held bytes then drain
// one per cycle while the output is not stalled, paced by the registered
// read of the byte RAM. One item is in work at a time. A capacity write
// restarts the stream; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module stream_byte_reassembler #(
	parameter int BUFFER_BYTES = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [6:0]  stream_capacity,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  action,
	input  wire logic [63:0] position,
	input  wire logic [7:0]  byte_value,
	input  wire logic        is_final_byte,
	input  wire logic [6:0]  consumed_count,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic             has_byte,
	output logic [7:0]       out_byte,
	output logic             stream_closed,
	output logic [6:0]       pending_bytes,
	output logic             last_result
);

	localparam int CNT_W  = sbr_pkg::CNT_W;
	localparam int POS_W  = sbr_pkg::POS_W;
	localparam int SLOT_W = $clog2(BUFFER_BYTES);
	localparam logic [CNT_W-1:0]  CAP_MAX  = CNT_W'(BUFFER_BYTES);
	localparam logic [SLOT_W-1:0] SLOT_TOP = SLOT_W'(BUFFER_BYTES - 1);
	localparam logic [CNT_W:0]    SUM_LIM  = (CNT_W+1)'(BUFFER_BYTES);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_EVAL  = 2'd1;
	localparam logic [1:0] ST_ACT   = 2'd2;
	localparam logic [1:0] ST_DRAIN = 2'd3;

	logic [1:0]              state_q, state_d;
	logic [POS_W-1:0]        next_q, next_d;
	logic [POS_W-1:0]        next_p1_q, next_p1_d;
	logic [SLOT_W-1:0]       nslot_q, nslot_d, nslot_inc;
	logic [CNT_W-1:0]        free_q, free_d;
	logic [CNT_W-1:0]        pend_q, pend_d;
	logic                    end_known_q, end_known_d;
	logic [POS_W-1:0]        end_q, end_d;
	logic                    closed_q, closed_d;
	logic [CNT_W-1:0]        cap_q;
	logic [BUFFER_BYTES-1:0] valid_q;

	// captured item
	logic [1:0]       action_q;
	logic [POS_W-1:0] pos_q;
	logic [7:0]       val_q;
	logic [CNT_W-1:0] consumed_q;
	logic [POS_W-1:0] end_cand_q;
	logic             upd_end_q;

	// compare results
	logic              close0_q, close1_q, past_q, eq_q, gt_q, fit_q;
	logic [SLOT_W-1:0] slot_st_q;

	logic              accept, cfg_wr;
	logic [CNT_W-1:0]  cap_new;
	logic [POS_W-1:0]  end_eff;
	logic              known_eff;
	logic [POS_W:0]    diff;
	logic [CNT_W:0]    ssum, ssum_w;
	logic [CNT_W-1:0]  held, take;

	logic              clr_all, set_v, clr_v, more;
	logic [SLOT_W-1:0] set_idx;

	logic              load, out_rdy;
	sbr_pkg::res_t     res, res_out;

	logic              ram_we, ram_re;
	logic [SLOT_W-1:0] ram_raddr;
	logic [7:0]        ram_rdata;

	assign accept    = in_valid && !in_stall;
	assign in_stall  = (state_q != ST_IDLE) || cfg_valid;
	assign cfg_ready = (state_q == ST_IDLE);
	assign cfg_wr    = cfg_valid && cfg_ready;

	always_comb begin
		if (stream_capacity == '0) begin
			cap_new = CNT_W'(1);
		end else if (stream_capacity > CAP_MAX) begin
			cap_new = CAP_MAX;
		end else begin
			cap_new = stream_capacity;
		end
	end

	assign nslot_inc = (nslot_q == SLOT_TOP) ? '0 : nslot_q + 1'b1;

	// compare stage
	always_comb begin
		end_eff   = upd_end_q ? end_cand_q : end_q;
		known_eff = upd_end_q || end_known_q;
		diff      = {1'b0, pos_q} - {1'b0, next_q};
		ssum      = {1'b0, CNT_W'(nslot_q)} + {1'b0, diff[CNT_W-1:0]};
		ssum_w    = (ssum >= SUM_LIM) ? ssum - SUM_LIM : ssum;
	end

	assign held = cap_q - free_q;
	assign take = (consumed_q > held) ? held : consumed_q;

	always_comb begin
		state_d     = state_q;
		next_d      = next_q;
		next_p1_d   = next_p1_q;
		nslot_d     = nslot_q;
		free_d      = free_q;
		pend_d      = pend_q;
		end_known_d = end_known_q;
		end_d       = end_q;
		closed_d    = closed_q;
		clr_all     = 1'b0;
		set_v       = 1'b0;
		clr_v       = 1'b0;
		set_idx     = slot_st_q;
		more        = 1'b0;
		load        = 1'b0;
		ram_we      = 1'b0;
		ram_re      = 1'b0;
		ram_raddr   = nslot_inc;
		res         = '0;

		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_EVAL;
				end
			end
			ST_EVAL: begin
				state_d = ST_ACT;
			end
			ST_ACT: begin
				if (out_rdy) begin
					load    = 1'b1;
					state_d = ST_IDLE;
					unique case (action_q)
						sbr_pkg::ACT_CONSUME: begin
							free_d = free_q + take;
						end
						sbr_pkg::ACT_END: begin
							if (!closed_q) begin
								end_known_d = 1'b1;
								end_d       = end_cand_q;
								if (close0_q) begin
									closed_d = 1'b1;
									clr_all  = 1'b1;
									pend_d   = '0;
								end
							end
						end
						sbr_pkg::ACT_DATA: begin
							if (!closed_q) begin
								if (upd_end_q) begin
									end_known_d = 1'b1;
									end_d       = end_cand_q;
								end
								if (close0_q) begin
									closed_d = 1'b1;
									clr_all  = 1'b1;
									pend_d   = '0;
								end else if (eq_q) begin
									if (free_q != '0) begin
										next_d       = next_p1_q;
										next_p1_d    = next_p1_q + 1'b1;
										nslot_d      = nslot_inc;
										free_d       = free_q - 1'b1;
										res.has_byte = 1'b1;
										res.out_byte = val_q;
										if (close1_q) begin
											closed_d = 1'b1;
											clr_all  = 1'b1;
											pend_d   = '0;
										end
										more = !close1_q && (free_d != '0) &&
											valid_q[nslot_inc];
										if (more) begin
											ram_re  = 1'b1;
											state_d = ST_DRAIN;
										end
									end
								end else if (gt_q && fit_q && !past_q &&
									!valid_q[slot_st_q]) begin
									ram_we = 1'b1;
									set_v  = 1'b1;
									pend_d = pend_q + 1'b1;
								end
							end
						end
						default: begin
						end
					endcase
				end
			end
			ST_DRAIN: begin
				if (out_rdy) begin
					load         = 1'b1;
					res.has_byte = 1'b1;
					res.out_byte = ram_rdata;
					clr_v        = 1'b1;
					pend_d       = pend_q - 1'b1;
					next_d       = next_p1_q;
					next_p1_d    = next_p1_q + 1'b1;
					nslot_d      = nslot_inc;
					free_d       = free_q - 1'b1;
					if (end_known_q && (next_p1_q >= end_q)) begin
						closed_d = 1'b1;
						clr_all  = 1'b1;
						pend_d   = '0;
					end
					more = !closed_d && (free_d != '0) && valid_q[nslot_inc];
					if (more) begin
						ram_re = 1'b1;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
		endcase

		res.stream_closed = closed_d;
		res.pending_bytes = pend_d;
		res.last_result   = !more;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			next_q      <= '0;
			next_p1_q   <= POS_W'(1);
			nslot_q     <= '0;
			free_q      <= CAP_MAX;
			pend_q      <= '0;
			end_known_q <= 1'b0;
			end_q       <= '0;
			closed_q    <= 1'b0;
			cap_q       <= CAP_MAX;
			valid_q     <= '0;
		end else if (cfg_wr) begin
			state_q     <= ST_IDLE;
			next_q      <= '0;
			next_p1_q   <= POS_W'(1);
			nslot_q     <= '0;
			free_q      <= cap_new;
			pend_q      <= '0;
			end_known_q <= 1'b0;
			end_q       <= '0;
			closed_q    <= 1'b0;
			cap_q       <= cap_new;
			valid_q     <= '0;
		end else begin
			state_q     <= state_d;
			next_q      <= next_d;
			next_p1_q   <= next_p1_d;
			nslot_q     <= nslot_d;
			free_q      <= free_d;
			pend_q      <= pend_d;
			end_known_q <= end_known_d;
			end_q       <= end_d;
			closed_q    <= closed_d;
			if (clr_all) begin
				valid_q <= '0;
			end else begin
				if (set_v) begin
					valid_q[set_idx] <= 1'b1;
				end
				if (clr_v) begin
					valid_q[nslot_q] <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			action_q   <= action;
			pos_q      <= position;
			val_q      <= byte_value;
			consumed_q <= consumed_count;
			end_cand_q <= (action == sbr_pkg::ACT_END) ? position : position + 1'b1;
			upd_end_q  <= (action == sbr_pkg::ACT_END) ||
				((action == sbr_pkg::ACT_DATA) && is_final_byte);
		end
		if (state_q == ST_EVAL) begin
			close0_q  <= known_eff && (next_q >= end_eff);
			close1_q  <= known_eff && (next_p1_q >= end_eff);
			past_q    <= known_eff && (pos_q >= end_eff);
			eq_q      <= (pos_q == next_q);
			gt_q      <= !diff[POS_W] && (pos_q != next_q);
			fit_q     <= (diff[POS_W-1:CNT_W] == '0) && (diff[CNT_W-1:0] < free_q);
			slot_st_q <= ssum_w[SLOT_W-1:0];
		end
	end

	// stores and drain reads never hit the same cycle; valid bits order them
	sbr_ram #(
		.WIDTH(8),
		.DEPTH(BUFFER_BYTES)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (slot_st_q),
		.wdata (val_q),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	sbr_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (load),
		.res       (res),
		.rdy       (out_rdy),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.res_out   (res_out)
	);

	assign has_byte      = res_out.has_byte;
	assign out_byte      = res_out.out_byte;
	assign stream_closed = res_out.stream_closed;
	assign pending_bytes = res_out.pending_bytes;
	assign last_result   = res_out.last_result;

endmodule

`default_nettype wire

### design/sbr_ram.sv
// ----------------------------------------------------------------------------
// sbr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module sbr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

### design/sbr_outq.sv
// ----------------------------------------------------------------------------
// sbr_outq
// Output register for result transactions, decoupling the core from stall.
// ----------------------------------------------------------------------------
`default_nettype none

module sbr_outq (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          load,
	input  wire sbr_pkg::res_t res,
	output logic               rdy,
	output logic               out_valid,
	input  wire logic          out_stall,
	output sbr_pkg::res_t      res_out
);

	logic          valid_q;
	sbr_pkg::res_t res_q;

	assign rdy       = !valid_q || !out_stall;
	assign out_valid = valid_q;
	assign res_out   = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (!out_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

endmodule

`default_nettype wire

### design/sbr_checker.sv
// ----------------------------------------------------------------------------
// sbr_checker
// Port-level checks for the stream byte reassembler, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module sbr_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_stall,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic        has_byte,
	input wire logic [7:0]  out_byte,
	input wire logic        stream_closed,
	input wire logic [6:0]  pending_bytes,
	input wire logic        last_result
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(has_byte) &&
			$stable(out_byte) && $stable(last_result) && $stable(pending_bytes))
		else $error("stalled result transaction changed");

	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !has_byte |-> last_result && (out_byte == 8'd0))
		else $error("status result not last or carries data");

	a_closed_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && stream_closed |-> pending_bytes == 7'd0)
		else $error("closed stream still reports held bytes");

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("second transaction taken while one is in work");

endmodule

bind stream_byte_reassembler sbr_checker u_sbr_checker (.*);

`default_nettype wire

### verif/stream_byte_reassembler_tb.sv
// ----------------------------------------------------------------------------
// stream_byte_reassembler_tb
// Self-checking bench for the stream byte reassembler. Drives positioned
// bytes, end marks and reader consumption through the input channel, and
// changes the stream capacity between phases. A scoreboard mirrors the
// reorder store, the output room and the close logic to predict every result
// transaction, then checks the result stream field by field, in order.
// Directed corner cases come first, then random traffic near the expected
// position under three sender and receiver idle profiles.
// ----------------------------------------------------------------------------
`default_nettype none

module stream_byte_reassembler_tb;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int BUFFER_BYTES = 64;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int ITEMS_PER_PHASE = 160;
	localparam logic [1:0] ACT_UNUSED = 2'd3;

	class reassembly_scoreboard;
		logic [7:0]    held_bytes[BUFFER_BYTES];
		bit            held_valid[BUFFER_BYTES];
		logic [63:0]   next_pos;
		logic [63:0]   end_pos;
		int unsigned   capacity;
		int unsigned   room;
		int unsigned   pending;
		bit            end_known;
		bit            closed;
		sbr_pkg::res_t expected_q[$];
		int            errors;
		int            results_seen;
		int            closes;

		function new();
			capacity = BUFFER_BYTES;
			errors = 0;
			results_seen = 0;
			closes = 0;
			restart();
		endfunction

		function void restart();
			foreach (held_valid[i])
				held_valid[i] = 1'b0;
			next_pos = '0;
			end_pos = '0;
			room = capacity;
			pending = 0;
			end_known = 1'b0;
			closed = 1'b0;
		endfunction

		function void set_capacity(logic [6:0] value);
			if (value < 1)
				capacity = 1;
			else if (value > BUFFER_BYTES)
				capacity = BUFFER_BYTES;
			else
				capacity = 32'(value);
			restart();
		endfunction

		function void close_if_done();
			if (end_known && next_pos >= end_pos) begin
				if (!closed)
					closes++;
				closed = 1'b1;
				foreach (held_valid[i])
					held_valid[i] = 1'b0;
				pending = 0;
			end
		endfunction

		function void push_result(bit has, logic [7:0] b);
			sbr_pkg::res_t r;
			r.has_byte = has;
			r.out_byte = has ? b : 8'h00;
			r.stream_closed = closed;
			r.pending_bytes = pending[6:0];
			r.last_result = 1'b0;
			expected_q.push_back(r);
		endfunction

		function void note_input(logic [1:0] act, logic [63:0] pos, logic [7:0] val,
				logic fin, logic [6:0] cnt);
			int unsigned first;
			int unsigned held;
			int unsigned take;
			int unsigned slot;
			sbr_pkg::res_t tail;
			first = expected_q.size();
			case (act)
			sbr_pkg::ACT_CONSUME: begin
				held = capacity - room;
				take = 32'(cnt);
				if (take > held)
					take = held;
				room += take;
			end
			sbr_pkg::ACT_END: begin
				if (!closed) begin
					end_known = 1'b1;
					end_pos = pos;
					close_if_done();
				end
			end
			sbr_pkg::ACT_DATA: begin
				if (!closed) begin
					if (fin) begin
						end_known = 1'b1;
						end_pos = pos + 64'd1;
						close_if_done();
					end
					if (!closed && pos == next_pos) begin
						if (room > 0) begin
							next_pos++;
							room--;
							close_if_done();
							push_result(1'b1, val);
							slot = 32'(next_pos % BUFFER_BYTES);
							while (!closed && room > 0 && held_valid[slot]) begin
								held_valid[slot] = 1'b0;
								pending--;
								next_pos++;
								room--;
								close_if_done();
								push_result(1'b1, held_bytes[slot]);
								slot = 32'(next_pos % BUFFER_BYTES);
							end
						end
					end else if (!closed && pos > next_pos) begin
						if ((pos - next_pos) < room && !(end_known && pos >= end_pos)) begin
							slot = 32'(pos % BUFFER_BYTES);
							if (!held_valid[slot]) begin
								held_bytes[slot] = val;
								held_valid[slot] = 1'b1;
								pending++;
							end
						end
					end
				end
			end
			default: ;
			endcase
			if (expected_q.size() == first)
				push_result(1'b0, 8'h00);
			tail = expected_q.pop_back();
			tail.last_result = 1'b1;
			expected_q.push_back(tail);
		endfunction

		task report(string msg);
			$display("[%0t] mismatch: %s", $time, msg);
			errors++;
		endtask

		task check_result(sbr_pkg::res_t got);
			sbr_pkg::res_t want;
			results_seen++;
			if (expected_q.size() == 0) begin
				report($sformatf("result %0d arrived with nothing expected", results_seen));
				return;
			end
			want = expected_q.pop_front();
			if (got.has_byte !== want.has_byte)
				report($sformatf("result %0d has_byte %0b, expected %0b",
					results_seen, got.has_byte, want.has_byte));
			if (got.out_byte !== want.out_byte)
				report($sformatf("result %0d out_byte %02h, expected %02h",
					results_seen, got.out_byte, want.out_byte));
			if (got.stream_closed !== want.stream_closed)
				report($sformatf("result %0d stream_closed %0b, expected %0b",
					results_seen, got.stream_closed, want.stream_closed));
			if (got.pending_bytes !== want.pending_bytes)
				report($sformatf("result %0d pending_bytes %0d, expected %0d",
					results_seen, got.pending_bytes, want.pending_bytes));
			if (got.last_result !== want.last_result)
				report($sformatf("result %0d last_result %0b, expected %0b",
					results_seen, got.last_result, want.last_result));
		endtask
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [6:0]  stream_capacity = 7'd64;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  action = sbr_pkg::ACT_DATA;
	logic [63:0] position = '0;
	logic [7:0]  byte_value = '0;
	logic        is_final_byte = 1'b0;
	logic [6:0]  consumed_count = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        has_byte;
	logic [7:0]  out_byte;
	logic        stream_closed;
	logic [6:0]  pending_bytes;
	logic        last_result;

	reassembly_scoreboard sb;
	int send_gap_pct = 0;
	int recv_stall_pct = 0;
	int items_sent = 0;
	int cfg_writes = 0;
	int idle_cycles = 0;

	stream_byte_reassembler #(
		.BUFFER_BYTES(BUFFER_BYTES)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.stream_capacity(stream_capacity),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.action(action),
		.position(position),
		.byte_value(byte_value),
		.is_final_byte(is_final_byte),
		.consumed_count(consumed_count),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.has_byte(has_byte),
		.out_byte(out_byte),
		.stream_closed(stream_closed),
		.pending_bytes(pending_bytes),
		.last_result(last_result)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
	end

	always @(posedge clk) begin
		sbr_pkg::res_t got;
		if (arst_n && out_valid && !out_stall) begin
			got.has_byte = has_byte;
			got.out_byte = out_byte;
			got.stream_closed = stream_closed;
			got.pending_bytes = pending_bytes;
			got.last_result = last_result;
			sb.check_result(got);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("[%0t] watchdog: no transaction for %0d cycles", $time, idle_cycles);
				$display("stream_byte_reassembler regression: fail");
				$finish;
			end
		end
	end

	task send_item(logic [1:0] act, logic [63:0] pos, logic [7:0] val, logic fin,
			logic [6:0] cnt);
		if ($urandom_range(0, 99) < send_gap_pct) begin
			in_valid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(0, 99) < send_gap_pct);
		end
		action <= act;
		position <= pos;
		byte_value <= val;
		is_final_byte <= fin;
		consumed_count <= cnt;
		in_valid <= 1'b1;
		do
			@(posedge clk);
		while (in_stall);
		sb.note_input(act, pos, val, fin, cnt);
		if (act != ACT_UNUSED)
			items_sent++;
	endtask

	task wait_drained();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (sb.expected_q.size() != 0);
	endtask

	task write_capacity(logic [6:0] value);
		wait_drained();
		repeat (8) @(posedge clk);
		stream_capacity <= value;
		cfg_valid <= 1'b1;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		sb.set_capacity(value);
		cfg_writes++;
	endtask

	function logic [6:0] pick_capacity();
		case ($urandom_range(0, 7))
		0: return 7'd1;
		1: return 7'd2;
		2: return 7'd64;
		3: return 7'd0;
		4: return 7'd127;
		5: return 7'($urandom_range(65, 126));
		default: return 7'($urandom_range(1, 63));
		endcase
	endfunction

	task random_item();
		int unsigned r;
		int unsigned span;
		int unsigned held;
		logic [6:0] cnt;
		r = $urandom_range(0, 99);
		span = sb.room + 2;
		held = sb.capacity - sb.room;
		cnt = 7'($urandom_range(0, 64));
		if (r < 58)
			send_item(sbr_pkg::ACT_DATA, sb.next_pos + $urandom_range(0, span),
				8'($urandom_range(0, 255)), $urandom_range(0, 99) < 3, cnt);
		else if (r < 64)
			send_item(sbr_pkg::ACT_DATA, sb.next_pos - $urandom_range(1, 8),
				8'($urandom_range(0, 255)), $urandom_range(0, 99) < 3, cnt);
		else if (r < 68)
			send_item(sbr_pkg::ACT_DATA, {$urandom(), $urandom()}, 8'($urandom_range(0, 255)),
				1'($urandom_range(0, 1)), cnt);
		else if (r < 86) begin
			if ($urandom_range(0, 9) == 0)
				cnt = 7'd64;
			else
				cnt = 7'($urandom_range(0, (held + 2 > 64) ? 64 : held + 2));
			send_item(sbr_pkg::ACT_CONSUME, {$urandom(), $urandom()},
				8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), cnt);
		end else if (r < 89)
			send_item(sbr_pkg::ACT_END, sb.next_pos + $urandom_range(0, span + 2),
				8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), cnt);
		else if (r < 92)
			send_item(ACT_UNUSED, {$urandom(), $urandom()}, 8'($urandom_range(0, 255)),
				1'($urandom_range(0, 1)), cnt);
		else
			send_item(sbr_pkg::ACT_DATA, sb.next_pos, 8'($urandom_range(0, 255)), 1'b0, cnt);
	endtask

	initial begin
		int target;
		sb = new();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_gap_pct = 14;
		recv_stall_pct = 53;

		// default capacity: store, duplicate, window edges, drain, saturating consume
		send_item(sbr_pkg::ACT_DATA, 64'd1, 8'hAA, 1'b0, 7'd0);
		send_item(sbr_pkg::ACT_DATA, 64'd1, 8'h55, 1'b0, 7'd0);
		send_item(sbr_pkg::ACT_DATA, 64'd63, 8'hFF, 1'b0, 7'd0);
		send_item(sbr_pkg::ACT_DATA, 64'd64, 8'h12, 1'b0, 7'd0);
		send_item(sbr_pkg::ACT_DATA, 64'd0, 8'h00, 1'b0, 7'd0);
		send_item(sbr_pkg::ACT_DATA, 64'd0, 8'h34, 1'b0, 7'd0);
		send_item(sbr_pkg::ACT_DATA, 64'hFFFF_FFFF_FFFF_FFFF, 8'h5A, 1'b0, 7'd0);
		send_item(sbr_pkg::ACT_CONSUME, 64'd0, 8'h00, 1'b0, 7'd64);
		send_item(ACT_UNUSED, 64'd2, 8'h77, 1'b1, 7'd5);
		send_item(sbr_pkg::ACT_CONSUME, 64'd0, 8'h00, 1'b0, 7'd0);

		// capacity 1: full output, close on final byte, closed-stream behavior
		write_capacity(7'd1);
		send_item(sbr_pkg::ACT_DATA, 64'd0, 8'h81, 1'b0, 7'd0);
		send_item(sbr_pkg::ACT_DATA, 64'd1, 8'h82, 1'b0, 7'd0);
		send_item(sbr_pkg::ACT_DATA, 64'd2, 8'h83, 1'b0, 7'd0);
		send_item(sbr_pkg::ACT_CONSUME, 64'd0, 8'h00, 1'b0, 7'd1);
		send_item(sbr_pkg::ACT_DATA, 64'd1, 8'h84, 1'b1, 7'd0);
		send_item(sbr_pkg::ACT_DATA, 64'd2, 8'h85, 1'b0, 7'd0);
		send_item(sbr_pkg::ACT_END, 64'd9, 8'h00, 1'b0, 7'd0);
		send_item(sbr_pkg::ACT_CONSUME, 64'd0, 8'h00, 1'b0, 7'd5);

		// clamped capacities, end mark ahead, drop past end, discard on close
		write_capacity(7'd0);
		write_capacity(7'd127);
		send_item(sbr_pkg::ACT_DATA, 64'd2, 8'h22, 1'b0, 7'd0);
		send_item(sbr_pkg::ACT_DATA, 64'd5, 8'h55, 1'b0, 7'd0);
		send_item(sbr_pkg::ACT_END, 64'd4, 8'h00, 1'b0, 7'd0);
		send_item(sbr_pkg::ACT_DATA, 64'd4, 8'h44, 1'b0, 7'd0);
		send_item(sbr_pkg::ACT_DATA, 64'd0, 8'h00, 1'b0, 7'd0);
		send_item(sbr_pkg::ACT_DATA, 64'd1, 8'h11, 1'b0, 7'd0);
		send_item(sbr_pkg::ACT_DATA, 64'd3, 8'h33, 1'b0, 7'd0);

		// end position wraps to zero
		write_capacity(7'd64);
		send_item(sbr_pkg::ACT_DATA, 64'hFFFF_FFFF_FFFF_FFFF, 8'hFF, 1'b1, 7'd0);

		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
			0: begin
				send_gap_pct = 14;
				recv_stall_pct = 53;
			end
			1: begin
				send_gap_pct = 53;
				recv_stall_pct = 14;
			end
			default: begin
				send_gap_pct = 0;
				recv_stall_pct = 0;
			end
			endcase
			write_capacity(pick_capacity());
			target = items_sent + ITEMS_PER_PHASE;
			while (items_sent < target) begin
				if (sb.closed || $urandom_range(0, 99) < 2)
					write_capacity(pick_capacity());
				if (items_sent == target - ITEMS_PER_PHASE / 2)
					wait_drained();
				random_item();
			end
		end

		wait_drained();
		repeat (16) @(posedge clk);

		$display("ran %0d input transactions, %0d result transactions checked",
			items_sent, sb.results_seen);
		$display("%0d capacity writes, %0d stream closes, %0d mismatches",
			cfg_writes, sb.closes, sb.errors);
		if (sb.errors == 0 && sb.expected_q.size() == 0)
			$display("stream_byte_reassembler regression: pass");
		else
			$display("stream_byte_reassembler regression: fail");
		$finish;
	end

endmodule

`default_nettype wire
